/* rtl/elf_stream_loader_macros.svh */
// Assertion macros used by the loader sequencer.
// Depends on nothing; included by files that assert.
`ifndef ELF_STREAM_LOADER_MACROS_SVH
`define ELF_STREAM_LOADER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ESL_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ESL_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/esl_pkg.sv */
// Types and constants for the ELF stream loader.
// Depends on nothing.
`timescale 1ns / 1ps
package esl_pkg;
    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_FILL   = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_MAGIC  = 3'd3;
    localparam logic [2:0] KIND_HDRBIG = 3'd4;
    localparam logic [2:0] KIND_ORDER  = 3'd5;
    localparam logic [31:0] ELF_MAGIC  = 32'h464C457F;
    localparam int unsigned HDR_BYTES  = 52;

    // Datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_HDR     = 4'd1;
    localparam logic [3:0] OP_PHDR    = 4'd2;
    localparam logic [3:0] OP_SCAN    = 4'd3;  // begin reading a field
    localparam logic [3:0] OP_RDSTEP  = 4'd4;  // one byte of field read
    localparam logic [3:0] OP_SKIP    = 4'd5;
    localparam logic [3:0] OP_LOAD    = 4'd6;
    localparam logic [3:0] OP_SETSEG  = 4'd7;  // latch paddr as write address, compute skip
    localparam logic [3:0] OP_SETLEN  = 4'd8;  // remaining = filesz
    localparam logic [3:0] OP_NEXTSEG = 4'd9;
    localparam logic [3:0] OP_ZSEG    = 4'd10;
    localparam logic [3:0] OP_SAVE    = 4'd11;  // save read field to slot

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] field;  // field word index (offset/4)
        logic [1:0] rd_byte;
        logic [2:0] slot;
        logic [7:0] rx;
    } t_cmd;

    typedef struct packed {
        logic        hdr_done;   // 52nd header byte taken
        logic        tbl_big;
        logic        tbl_zero;
        logic        phdr_done;
        logic        magic_ok;
        logic        seg_end;    // segment_index >= ph_count
        logic        skip_zero;  // remaining hits zero
        logic        is_load;
        logic        off_behind;
        logic        off_equal;
        logic        fill_need;
        logic [31:0] fill_addr;
        logic [31:0] fill_len;
        logic [31:0] wr_addr;
        logic [31:0] entry;
    } t_stat;
endpackage

/* rtl/esl_if.sv */
// Valid/ready stream interface with a typed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface esl_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/esl_datapath.sv */
// Loader datapath: header fields, program header store, segment registers.
// Depends on esl_pkg.
`timescale 1ns / 1ps
module esl_datapath #(
    parameter int PHDR_BYTES = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esl_pkg::t_cmd i_cmd,
    output esl_pkg::t_stat o_stat
);
    import esl_pkg::*;
    localparam int AW = $clog2(PHDR_BYTES);

    logic [7:0]  r_mem [PHDR_BYTES];
    logic [7:0]  r_rd;
    logic [31:0] r_pos, r_magic, r_entry, r_rem, r_waddr;
    logic [15:0] r_esize, r_count;
    logic [15:0] r_seg;
    logic [31:0] r_field;
    logic [31:0] r_off, r_paddr, r_fsz, r_msz, r_type;
    logic        r_rd_ok;
    logic [32:0] r_tbl;
    logic [31:0] r_base;

    logic [32:0] rd_addr;
    logic [31:0] phidx;
    logic [31:0] pos_inc;
    logic [32:0] diff;
    logic [31:0] n_rem;
    logic [31:0] tbl_prod;

    assign pos_inc  = r_pos + 32'd1;
    assign phidx    = r_pos - 32'(HDR_BYTES);
    assign rd_addr  = {1'b0, r_base} + 33'({i_cmd.field, 2'b00}) + 33'(i_cmd.rd_byte);
    assign diff     = {1'b0, r_off} - {1'b0, r_pos};
    assign n_rem    = r_rem - 32'd1;
    assign tbl_prod = 32'(r_esize) * 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PHDR && phidx < 32'(PHDR_BYTES)) begin
            r_mem[phidx[AW-1:0]] <= i_cmd.rx;
        end
        r_rd    <= r_mem[rd_addr[AW-1:0]];
        r_rd_ok <= (rd_addr < r_tbl) && (rd_addr < 33'(PHDR_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_magic <= '0; r_entry <= '0; r_esize <= '0; r_count <= '0;
            r_seg <= '0; r_rem <= '0; r_waddr <= '0; r_base <= '0; r_tbl <= '0;
        end else begin
            r_tbl <= {1'b0, tbl_prod};
            case (i_cmd.op)
                OP_HDR: begin
                    r_pos <= pos_inc;
                    if (r_pos < 32'd4) r_magic[8*r_pos[1:0] +: 8] <= i_cmd.rx;
                    else if (r_pos >= 32'd24 && r_pos < 32'd28)
                        r_entry[8*r_pos[1:0] +: 8] <= i_cmd.rx;
                    else if (r_pos == 32'd42) r_esize[7:0] <= i_cmd.rx;
                    else if (r_pos == 32'd43) r_esize[15:8] <= i_cmd.rx;
                    else if (r_pos == 32'd44) r_count[7:0] <= i_cmd.rx;
                    else if (r_pos == 32'd45) r_count[15:8] <= i_cmd.rx;
                end
                OP_PHDR: r_pos <= pos_inc;
                OP_ZSEG: begin r_seg <= '0; r_base <= '0; end
                OP_NEXTSEG: begin
                    r_seg  <= r_seg + 16'd1;
                    r_base <= r_base + 32'(r_esize);
                end
                OP_SETSEG: begin
                    r_waddr <= r_paddr;
                    r_rem   <= diff[31:0];
                end
                OP_SETLEN: r_rem <= r_fsz;
                OP_SKIP: begin r_pos <= pos_inc; r_rem <= n_rem; end
                OP_LOAD: begin
                    r_pos <= pos_inc; r_rem <= n_rem; r_waddr <= r_waddr + 32'd1;
                end
                default: ;
            endcase
        end
    end

    // Field assembly: one byte per cycle, slot selects destination
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SCAN) r_field <= '0;
        else if (i_cmd.op == OP_RDSTEP)
            r_field <= {(r_rd_ok ? r_rd : 8'd0), r_field[31:8]};
        if (i_cmd.op == OP_SAVE) begin
            case (i_cmd.slot)
                3'd0: r_type  <= r_field;
                3'd1: r_off   <= r_field;
                3'd2: r_paddr <= r_field;
                3'd3: r_fsz   <= r_field;
                default: r_msz <= r_field;
            endcase
        end
    end

    logic [31:0] fd;
    logic [32:0] fl;
    always_comb begin
        fd = r_msz - r_fsz;
        fl = {1'b0, fd} + 33'd3;
        o_stat.hdr_done   = (pos_inc == 32'(HDR_BYTES));
        o_stat.tbl_big    = tbl_prod > 32'(PHDR_BYTES);
        o_stat.tbl_zero   = tbl_prod == 32'd0;
        o_stat.phdr_done  = {1'b0, pos_inc - 32'(HDR_BYTES)} >= r_tbl;
        o_stat.magic_ok   = r_magic == ELF_MAGIC;
        o_stat.seg_end    = r_seg >= r_count;
        o_stat.skip_zero  = n_rem == 32'd0;
        o_stat.is_load    = (r_type == 32'd1) && (r_fsz != 32'd0);
        o_stat.off_behind = r_off < r_pos;
        o_stat.off_equal  = r_off == r_pos;
        o_stat.fill_need  = r_msz > r_fsz;
        o_stat.fill_addr  = r_paddr + r_fsz;
        o_stat.fill_len   = fl[32] ? 32'hFFFFFFFC : {fl[31:2], 2'b00};
        o_stat.wr_addr    = r_waddr;
        o_stat.entry      = r_entry;
    end
endmodule

/* rtl/esl_ctrl.sv */
// Loader sequencer: drives datapath commands and forms result items.
// Depends on esl_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "elf_stream_loader_macros.svh"
module esl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_in_byte,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_kind,
    output logic [31:0]    o_address,
    output logic [7:0]     o_data,
    output logic [31:0]    o_length,
    output logic           o_last,
    output esl_pkg::t_cmd  o_cmd,
    input  esl_pkg::t_stat i_stat
);
    import esl_pkg::*;
    localparam logic [3:0] S_HDR = 4'd0, S_PHDR = 4'd1, S_SKIP = 4'd2, S_LOAD = 4'd3,
        S_DONE = 4'd4, S_SCAN = 4'd5, S_RD = 4'd6, S_SAVE = 4'd7, S_DECIDE = 4'd8,
        S_FILL = 4'd9, S_EMIT = 4'd10, S_LEN = 4'd11, S_SEL = 4'd12, S_TAIL = 4'd13,
        S_FLUSH = 4'd14;

    logic [3:0] r_st, n_st, r_ret, n_ret;
    logic [2:0] r_fi, n_fi;     // field step 0..4
    logic [2:0] r_bc, n_bc;     // byte counter 0..5
    logic       r_ov, n_ov;
    logic [2:0] r_kind, n_kind;
    logic [31:0] r_addr, n_addr, r_len, n_len;
    logic [7:0] r_dat, n_dat;
    logic       r_last, n_last;
    logic       r_wp, n_wp;     // segment's final write held in the result registers
    logic       r_fp, n_fp;     // zero fill pending
    logic       r_fv, n_fv;     // start or order error pending
    logic [2:0] r_fk, n_fk;
    logic [31:0] r_faddr, n_faddr, r_flen, n_flen;
    logic       take;
    logic [2:0] fld;

    // field word index for step: type, offset, paddr, filesz, memsz
    always_comb begin
        case (r_fi)
            3'd0: fld = 3'd0;
            3'd1: fld = 3'd1;
            3'd2: fld = 3'd3;
            3'd3: fld = 3'd4;
            default: fld = 3'd5;
        endcase
    end

    assign o_in_ready = !r_ov && (r_st == S_HDR || r_st == S_PHDR || r_st == S_SKIP
                        || r_st == S_LOAD || r_st == S_DONE);
    assign take = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_kind = r_kind; assign o_address = r_addr; assign o_data = r_dat;
    assign o_length = r_len; assign o_last = r_last;

    always_comb begin
        n_st = r_st; n_ret = r_ret; n_fi = r_fi; n_bc = r_bc;
        n_ov = r_ov && !i_out_ready;
        n_kind = r_kind; n_addr = r_addr; n_dat = r_dat; n_len = r_len; n_last = r_last;
        n_wp = r_wp; n_fp = r_fp; n_fv = r_fv; n_fk = r_fk;
        n_faddr = r_faddr; n_flen = r_flen;
        o_cmd = '{op: OP_NONE, field: fld, rd_byte: r_bc[1:0], slot: r_fi, rx: i_in_byte};
        unique case (r_st)
            S_HDR: if (take) begin
                o_cmd.op = OP_HDR;
                if (i_stat.hdr_done) n_st = S_SEL;  // decide after fields settle
            end
            S_SEL: begin
                if (i_stat.tbl_big) begin
                    n_ov = 1'b1; n_kind = KIND_HDRBIG; n_addr = '0; n_dat = '0;
                    n_len = '0; n_last = 1'b1; n_st = S_DONE;
                end else if (i_stat.tbl_zero) n_st = S_EMIT;
                else n_st = S_PHDR;
            end
            S_PHDR: if (take) begin
                o_cmd.op = OP_PHDR;
                if (i_stat.phdr_done) n_st = S_EMIT;
            end
            S_EMIT: begin  // magic check
                if (!i_stat.magic_ok) begin
                    n_ov = 1'b1; n_kind = KIND_MAGIC; n_addr = '0; n_dat = '0;
                    n_len = '0; n_last = 1'b1; n_st = S_DONE;
                end else begin
                    o_cmd.op = OP_ZSEG; n_st = S_SCAN;
                end
            end
            S_SCAN: if (!r_ov) begin
                if (i_stat.seg_end) begin
                    n_fv = 1'b1; n_fk = KIND_START; n_st = S_FLUSH;
                end else begin
                    o_cmd.op = OP_SCAN; n_fi = '0; n_bc = '0; n_st = S_RD;
                end
            end
            S_RD: begin
                // bc 0: address issued; 1..4 data arriving
                if (r_bc != 3'd0) o_cmd.op = OP_RDSTEP;
                o_cmd.rd_byte = r_bc[1:0];
                n_bc = r_bc + 3'd1;
                if (r_bc == 3'd4) n_st = S_SAVE;
            end
            S_SAVE: begin
                o_cmd.op = OP_SAVE;
                if (r_fi == 3'd4) n_st = S_DECIDE;
                else begin
                    n_fi = r_fi + 3'd1; n_bc = '0; n_st = S_LEN;
                end
            end
            S_LEN: begin o_cmd.op = OP_SCAN; n_st = S_RD; end
            S_DECIDE: begin
                if (!i_stat.is_load) begin
                    o_cmd.op = OP_NEXTSEG; n_st = S_SCAN;
                end else if (i_stat.off_behind) begin
                    n_fv = 1'b1; n_fk = KIND_ORDER; n_st = S_FLUSH;
                end else if (i_stat.off_equal) begin
                    o_cmd.op = OP_SETSEG; n_st = S_FLUSH; n_ret = S_FILL;
                end else begin
                    o_cmd.op = OP_SETSEG; n_st = S_FLUSH; n_ret = S_SKIP;
                end
            end
            S_FLUSH: if (!r_ov) begin
                // Release held results in order; last goes on the final one.
                if (r_wp) begin
                    n_ov = 1'b1; n_last = !(r_fp || r_fv); n_wp = 1'b0;
                end else if (r_fp) begin
                    n_ov = 1'b1; n_kind = KIND_FILL; n_addr = r_faddr; n_dat = '0;
                    n_len = r_flen; n_last = !r_fv; n_fp = 1'b0;
                end else if (r_fv) begin
                    n_ov = 1'b1; n_kind = r_fk;
                    n_addr = (r_fk == KIND_START) ? i_stat.entry : '0;
                    n_dat = '0; n_len = '0; n_last = 1'b1; n_fv = 1'b0; n_st = S_DONE;
                end else n_st = r_ret;
            end
            S_FILL: begin o_cmd.op = OP_SETLEN; n_st = S_LOAD; end
            S_SKIP: if (take) begin
                o_cmd.op = OP_SKIP;
                if (i_stat.skip_zero) n_st = S_FILL;
            end
            S_LOAD: if (take) begin
                o_cmd.op = OP_LOAD;
                n_kind = KIND_WRITE; n_addr = i_stat.wr_addr;
                n_dat = i_in_byte; n_len = '0; n_last = 1'b1;
                if (i_stat.skip_zero) begin
                    n_wp = 1'b1; n_st = S_TAIL;
                end else n_ov = 1'b1;
            end
            S_TAIL: begin  // segment tail: note the fill, then search on
                n_fp = i_stat.fill_need; n_faddr = i_stat.fill_addr;
                n_flen = i_stat.fill_len;
                o_cmd.op = OP_NEXTSEG; n_st = S_SCAN;
            end
            default: ;  // S_DONE: swallow bytes
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_HDR; r_ret <= S_LOAD; r_fi <= '0; r_bc <= '0; r_ov <= 1'b0;
            r_wp <= 1'b0; r_fp <= 1'b0; r_fv <= 1'b0;
        end else begin
            r_st <= n_st; r_ret <= n_ret; r_fi <= n_fi; r_bc <= n_bc; r_ov <= n_ov;
            r_wp <= n_wp; r_fp <= n_fp; r_fv <= n_fv;
        end
    end
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_addr <= n_addr; r_dat <= n_dat; r_len <= n_len;
        r_last <= n_last; r_fk <= n_fk; r_faddr <= n_faddr; r_flen <= n_flen;
    end

    `ESL_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_ov, !o_in_ready)
    `ESL_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, r_ov, r_kind <= KIND_ORDER)
    `ESL_ASSERT_NXT(a_done_stays, i_clk, i_rst_n, r_st == S_DONE, r_st == S_DONE)
    `ESL_ASSERT_IMP(a_held_blocks_in, i_clk, i_rst_n, r_wp, !o_in_ready)
endmodule

/* rtl/elf_stream_loader.sv */
// ELF stream loader top level: wires sequencer, datapath and stream ports.
// Depends on esl_pkg, esl_if, esl_ctrl and esl_datapath.
// Usage:
//   i_rx is a valid/ready byte stream carrying the ELF image in file order.
//   o_res delivers result items: byte writes, zero fills, start or an error.
//   Header and program header bytes are taken one per cycle. At the end of the
//   program header table, and after each segment, the next loadable entry is
//   searched: each table entry reads its five fields in turn, one store byte
//   read per cycle from the header memory, and then makes one decision.
//   No input is taken during the search.
//   A payload byte, other than a segment's final one, yields its write result in
//   the cycle after acceptance; the next byte is taken only once that result leaves.
//   The write of a segment's final byte is held until the search ends; then
//   write, zero fill and start or order error leave in that order, and last
//   marks the final result of that byte. All other results carry last = 1.
//   Reset (synchronous, active low) returns to reading the file header.
//   A stalled receiver holds the result; no input is taken meanwhile.
//   After start or an error, every further byte is accepted and dropped.
`timescale 1ns / 1ps
module elf_stream_loader #(
    parameter int PHDR_BYTES = 128
) (
    input logic  i_clk,
    input logic  i_rst_n,
    esl_if.sink  i_rx,
    esl_if.source o_res
);
    import esl_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic [2:0] kind; logic [31:0] addr; logic [7:0] dat; logic [31:0] len; logic lst;

    esl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_rx.valid), .i_in_byte(i_rx.payload), .o_in_ready(i_rx.ready),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .o_kind(kind), .o_address(addr), .o_data(dat), .o_length(len), .o_last(lst),
        .o_cmd(cmd), .i_stat(stat)
    );
    esl_datapath #(.PHDR_BYTES(PHDR_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat)
    );
    assign o_res.payload = {kind, addr, dat, len, lst};
endmodule
